// File: hdl/amr_pkg.sv
package amr_pkg;

  // Field widths
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int CMD_W   = 4;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;
  localparam int TICK_W  = 16;
  localparam int SIL_W   = 32;
  localparam int BREATH_W = 8;

  localparam int NUM_SLOTS_DEF = 17;

  // Register reset values
  localparam logic [TICK_W-1:0]   ROTATE_RST  = 16'd3000;
  localparam logic [TICK_W-1:0]   BLINK_RST   = 16'd500;
  localparam logic [TICK_W-1:0]   BUZZ_RST    = 16'd2000;
  localparam logic [SIL_W-1:0]    SILENCE_RST = 32'd120000;
  localparam logic [BREATH_W-1:0] STABLE_RST  = 8'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 4'd0,
    CMD_RAISE       = 4'd1,
    CMD_CLEAR       = 4'd2,
    CMD_CLEAR_SHOWN = 4'd3,
    CMD_CLEAR_ALL   = 4'd4,
    CMD_SILENCE_ON  = 4'd5,
    CMD_SILENCE_OFF = 4'd6,
    CMD_BREATH      = 4'd7,
    CMD_CYCLE_RESET = 4'd8
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROTATE    = 3'd0,
    CFG_BLINK     = 3'd1,
    CFG_BUZZ      = 3'd2,
    CFG_SILENCE   = 3'd3,
    CFG_STABLE    = 3'd4,
    CFG_RECORD    = 3'd5,
    CFG_BUZZ_EN   = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

// File: hdl/alarm_annunciator_rotator.sv
// Flow: an accepted item is captured, then applied in S_EXEC once the result
// register is free, and its result is registered. No new item is taken while
// the previous one is being applied in S_EXEC.
// A new item is taken while the previous result is still waiting.
// Reset: rst_n synchronous, active low; resets FSM and alarms, loads cfg defaults.
module alarm_annunciator_rotator #(
  parameter int NUM_SLOTS = amr_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [amr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [amr_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [amr_pkg::CMD_W-1:0]     in_cmd,
  input  logic [amr_pkg::IDX_W-1:0]     in_alarm_index,
  input  logic                          in_buzzer_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [amr_pkg::IDX_W-1:0]     out_shown_index,
  output logic                          out_shown_on,
  output logic                          out_any_active,
  output logic                          out_buzz_request,
  output logic                          out_buzz_wanted,
  output logic                          out_silenced,
  output logic [NUM_SLOTS-1:0]          out_active_mask,
  output logic [amr_pkg::IDX_W-1:0]     out_active_count,
  output logic                          out_stable,
  output logic [amr_pkg::BREATH_W-1:0]  out_cycle_count
);
  import amr_pkg::*;

  ctrl_t ctrl;

  // Sequencer
  amr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // Alarm state and timers
  amr_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_alarm_index   (in_alarm_index),
    .in_buzzer_busy   (in_buzzer_busy),
    .out_shown_index  (out_shown_index),
    .out_shown_on     (out_shown_on),
    .out_any_active   (out_any_active),
    .out_buzz_request (out_buzz_request),
    .out_buzz_wanted  (out_buzz_wanted),
    .out_silenced     (out_silenced),
    .out_active_mask  (out_active_mask),
    .out_active_count (out_active_count),
    .out_stable       (out_stable),
    .out_cycle_count  (out_cycle_count)
  );

`ifndef SYNTH
  // Count tracks the mask
  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_active_count) == $countones(out_active_mask)))
    else $error("active count does not match mask");

  // Display lit only with an alarm latched
  a_shown_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_shown_on) |-> out_any_active)
    else $error("display on with no alarm");

  // A buzzer request leaves the buzz-wanted flag set
  a_req_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_buzz_request) |-> out_buzz_wanted)
    else $error("buzz request without buzz-wanted flag");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while previous still in work");
`endif

endmodule

// File: hdl/amr_ctrl.sv
module amr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output amr_pkg::ctrl_t ctrl
);
  import amr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        // Apply the item once the result register is free
        if (!out_valid_r || out_ready) begin
          ctrl.execute = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    if (ctrl.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/amr_dp.sv
module amr_dp #(
  parameter int NUM_SLOTS = amr_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  amr_pkg::ctrl_t                ctrl,
  input  logic                          cfg_we,
  input  logic [amr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [amr_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic [amr_pkg::CMD_W-1:0]     in_cmd,
  input  logic [amr_pkg::IDX_W-1:0]     in_alarm_index,
  input  logic                          in_buzzer_busy,
  output logic [amr_pkg::IDX_W-1:0]     out_shown_index,
  output logic                          out_shown_on,
  output logic                          out_any_active,
  output logic                          out_buzz_request,
  output logic                          out_buzz_wanted,
  output logic                          out_silenced,
  output logic [NUM_SLOTS-1:0]          out_active_mask,
  output logic [amr_pkg::IDX_W-1:0]     out_active_count,
  output logic                          out_stable,
  output logic [amr_pkg::BREATH_W-1:0]  out_cycle_count
);
  import amr_pkg::*;

  localparam logic [NUM_SLOTS-1:0] ONE_HOT0 = NUM_SLOTS'(1);

  // Lowest set slot of a mask
  function automatic logic [IDX_W-1:0] first_set(input logic [NUM_SLOTS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] sat16(input logic [TICK_W-1:0] v);
    return (v == '1) ? v : v + TICK_W'(1);
  endfunction

  // Configuration registers
  logic [TICK_W-1:0]   cfg_rotate_r, cfg_blink_r, cfg_buzz_r;
  logic [SIL_W-1:0]    cfg_silence_r;
  logic [BREATH_W-1:0] cfg_stable_r;
  logic                cfg_record_r, cfg_buzz_en_r;

  // Captured item
  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;

  // Block state
  logic [NUM_SLOTS-1:0] latched_r, latched_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     shown_r, shown_nxt;
  logic                 single_r, single_nxt;
  logic [TICK_W-1:0]    rot_r, rot_nxt;
  logic [TICK_W-1:0]    blk_r, blk_nxt;
  logic                 phase_r, phase_nxt;
  logic [TICK_W-1:0]    buz_r, buz_nxt;
  logic                 sil_r, sil_nxt;
  logic [SIL_W-1:0]     sil_cnt_r, sil_cnt_nxt;
  logic                 wanted_r, wanted_nxt;
  logic [BREATH_W-1:0]  breath_r, breath_nxt;
  logic                 gate_r, gate_nxt;
  logic                 stable_r, stable_nxt;
  logic                 req;

  // Slot selection helpers
  logic [NUM_SLOTS-1:0] sel_idx, sel_shown, sel_clr, above;
  logic [TICK_W-1:0]    rot_inc, blk_inc, buz_inc;
  logic [IDX_W-1:0]     wrap_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rotate_r  <= ROTATE_RST;
      cfg_blink_r   <= BLINK_RST;
      cfg_buzz_r    <= BUZZ_RST;
      cfg_silence_r <= SILENCE_RST;
      cfg_stable_r  <= STABLE_RST;
      cfg_record_r  <= 1'b1;
      cfg_buzz_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROTATE:  cfg_rotate_r  <= cfg_wdata[TICK_W-1:0];
        CFG_BLINK:   cfg_blink_r   <= cfg_wdata[TICK_W-1:0];
        CFG_BUZZ:    cfg_buzz_r    <= cfg_wdata[TICK_W-1:0];
        CFG_SILENCE: cfg_silence_r <= cfg_wdata[SIL_W-1:0];
        CFG_STABLE:  cfg_stable_r  <= cfg_wdata[BREATH_W-1:0];
        CFG_RECORD:  cfg_record_r  <= cfg_wdata[0];
        CFG_BUZZ_EN: cfg_buzz_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_alarm_index;
      busy_r <= in_buzzer_busy;
    end
  end

  // Slot decode; an index past the last slot selects nothing
  assign sel_idx   = ONE_HOT0 << idx_r;
  assign sel_shown = ONE_HOT0 << shown_r;
  assign sel_clr   = (cmd_t'(cmd_r) == CMD_CLEAR) ? sel_idx : sel_shown;
  assign above     = latched_r & ~((sel_shown << 1) - ONE_HOT0);
  assign wrap_next = (|above) ? first_set(above) : first_set(latched_r);
  assign rot_inc   = sat16(rot_r);
  assign blk_inc   = sat16(blk_r);
  assign buz_inc   = sat16(buz_r);

  // Apply one item
  always_comb begin
    latched_nxt = latched_r;
    cnt_nxt     = cnt_r;
    shown_nxt   = shown_r;
    single_nxt  = single_r;
    rot_nxt     = rot_r;
    blk_nxt     = blk_r;
    phase_nxt   = phase_r;
    buz_nxt     = buz_r;
    sil_nxt     = sil_r;
    sil_cnt_nxt = sil_cnt_r;
    wanted_nxt  = wanted_r;
    breath_nxt  = breath_r;
    gate_nxt    = gate_r;
    stable_nxt  = stable_r;
    req         = 1'b0;
    unique case (cmd_t'(cmd_r))
      CMD_TICK: begin
        rot_nxt = rot_inc;
        blk_nxt = blk_inc;
        buz_nxt = buz_inc;
        if (cnt_r == '0) begin
          if (sil_r && sil_cnt_r != '1) sil_cnt_nxt = sil_cnt_r + SIL_W'(1);
        end else begin
          // Pick the lone alarm once, or rotate among several
          if (cnt_r == CNT_W'(1)) begin
            if (!single_r) begin
              shown_nxt  = first_set(latched_r);
              single_nxt = 1'b1;
            end
          end else if (rot_inc >= cfg_rotate_r) begin
            shown_nxt = wrap_next;
            rot_nxt   = '0;
          end
          // Toggle the blink phase
          if (blk_inc > cfg_blink_r) begin
            phase_nxt = ~phase_r;
            blk_nxt   = '0;
          end
          // Request the buzzer once per window
          if (!busy_r && buz_inc >= cfg_buzz_r) begin
            if (cfg_buzz_en_r && !sil_r) begin
              wanted_nxt = 1'b1;
              req        = 1'b1;
            end
            buz_nxt = '0;
          end
          // Expire the silence
          if (sil_r) begin
            if (sil_cnt_r >= cfg_silence_r) begin
              sil_nxt    = 1'b0;
              wanted_nxt = 1'b1;
            end else if (sil_cnt_r != '1) begin
              sil_cnt_nxt = sil_cnt_r + SIL_W'(1);
            end
          end
        end
      end
      CMD_RAISE: begin
        if (gate_r && cfg_record_r && (|sel_idx) && !(|(latched_r & sel_idx))) begin
          latched_nxt = latched_r | sel_idx;
          cnt_nxt     = cnt_r + CNT_W'(1);
          sil_nxt     = 1'b0;
        end
      end
      CMD_CLEAR, CMD_CLEAR_SHOWN: begin
        if (|(latched_r & sel_clr)) begin
          latched_nxt = latched_r & ~sel_clr;
          if (cnt_r <= CNT_W'(1)) begin
            cnt_nxt    = '0;
            single_nxt = 1'b0;
            wanted_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
            rot_nxt = '1;
            if (cnt_r == CNT_W'(2)) single_nxt = 1'b0;
          end
        end
      end
      CMD_CLEAR_ALL: begin
        latched_nxt = '0;
        cnt_nxt     = '0;
        wanted_nxt  = 1'b0;
      end
      CMD_SILENCE_ON: begin
        sil_nxt     = 1'b1;
        sil_cnt_nxt = '0;
      end
      CMD_SILENCE_OFF: begin
        sil_nxt = 1'b0;
      end
      CMD_BREATH: begin
        if (breath_r < cfg_stable_r) begin
          breath_nxt = breath_r + BREATH_W'(1);
        end else if (breath_r == cfg_stable_r) begin
          gate_nxt   = 1'b1;
          stable_nxt = 1'b1;
        end
      end
      CMD_CYCLE_RESET: begin
        breath_nxt = '0;
        gate_nxt   = 1'b0;
        stable_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= '0;
      cnt_r     <= '0;
      shown_r   <= '0;
      single_r  <= 1'b0;
      rot_r     <= '0;
      blk_r     <= '0;
      phase_r   <= 1'b0;
      buz_r     <= '0;
      sil_r     <= 1'b0;
      sil_cnt_r <= '0;
      wanted_r  <= 1'b0;
      breath_r  <= '0;
      gate_r    <= 1'b1;
      stable_r  <= 1'b0;
    end else if (ctrl.execute) begin
      latched_r <= latched_nxt;
      cnt_r     <= cnt_nxt;
      shown_r   <= shown_nxt;
      single_r  <= single_nxt;
      rot_r     <= rot_nxt;
      blk_r     <= blk_nxt;
      phase_r   <= phase_nxt;
      buz_r     <= buz_nxt;
      sil_r     <= sil_nxt;
      sil_cnt_r <= sil_cnt_nxt;
      wanted_r  <= wanted_nxt;
      breath_r  <= breath_nxt;
      gate_r    <= gate_nxt;
      stable_r  <= stable_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      out_shown_index  <= shown_nxt;
      out_shown_on     <= (cnt_nxt != '0) && phase_nxt;
      out_any_active   <= (cnt_nxt != '0);
      out_buzz_request <= req;
      out_buzz_wanted  <= wanted_nxt;
      out_silenced     <= sil_nxt;
      out_active_mask  <= latched_nxt;
      out_active_count <= cnt_nxt[IDX_W-1:0];
      out_stable       <= stable_nxt;
      out_cycle_count  <= breath_nxt;
    end
  end

endmodule
